[sv/pwts_pkg.sv]
package pwts_pkg;

	// fixed point format of all coordinates and coefficients
	localparam int FRAC_BITS = 16;

	localparam int COEF_W  = 32;
	localparam int SIZE_W  = 15;
	localparam int NEAR_W  = 31;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// matrix store: 4 rows of 4 coefficients
	localparam int MAT_DEPTH = 16;

	// datapath widths
	localparam int PROD_W = 2 * COEF_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int ROW_W  = SUM_W - FRAC_BITS + 1;
	localparam int N_W    = ROW_W + 1;
	localparam int MAG_W  = N_W;
	localparam int D_W    = ROW_W;
	localparam int NUM_W  = MAG_W + SIZE_W + FRAC_BITS;
	localparam int CMP_W  = (NUM_W > D_W + 33) ? NUM_W : D_W + 33;

	// divider: one quotient bit per stage, plus scale and saturation stages
	localparam int DIV_BITS = 32;
	localparam int DIV_LAT  = DIV_BITS + 2;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1920);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(1080);
	localparam logic [NEAR_W-1:0] NEAR_RST   = NEAR_W'(6554);

	localparam logic [31:0] NEG_ONE = ~((32'd1 << FRAC_BITS) - 32'd1);
	localparam logic [31:0] CAP_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] CAP_NEG = 32'h8000_0000;

	typedef enum logic {
		KIND_LOAD    = 1'b0,
		KIND_PROJECT = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_NEAR   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] screen_x;
		logic [31:0] screen_y;
		logic        behind;
	} res_t;

endpackage

[sv/pwts_if.sv]
interface pwts_item_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [1:0]         row_index;
	logic signed [31:0] coef_a;
	logic signed [31:0] coef_b;
	logic signed [31:0] coef_c;
	logic signed [31:0] coef_d;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;

	modport source (output valid, kind, row_index, coef_a, coef_b, coef_c, coef_d,
		point_x, point_y, point_z, input ready);
	modport sink (input valid, kind, row_index, coef_a, coef_b, coef_c, coef_d,
		point_x, point_y, point_z, output ready);
endinterface

interface pwts_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic               behind;

	modport source (output valid, screen_x, screen_y, behind, input ready);
	modport sink (input valid, screen_x, screen_y, behind, output ready);
endinterface

interface pwts_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/pwts_div.sv]
// Scales one numerator magnitude by the screen size and divides by 2w,
// one quotient bit per stage. Gives the signed, saturated 32-bit coordinate.
module pwts_div (
	input  logic                         clk,
	input  logic                         adv,
	input  logic [pwts_pkg::MAG_W-1:0]   mag,
	input  logic                         neg,
	input  logic [pwts_pkg::SIZE_W-1:0]  size,
	input  logic [pwts_pkg::D_W-1:0]     den,
	output logic [31:0]                  coord
);
	import pwts_pkg::*;

	// stage a: magnitude times screen size
	logic [MAG_W+SIZE_W-1:0] prod_sa;
	logic [D_W-1:0]          den_sa;
	logic                    neg_sa;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_sa <= MAG_W'(mag) * (MAG_W+SIZE_W)'(size);
			den_sa  <= den;
			neg_sa  <= neg;
		end
	end

	// divider stage arrays; entry 0 is the saturation stage
	logic [CMP_W-1:0]    rem_sd [DIV_BITS];
	logic [DIV_BITS-1:0] quo_sd [DIV_BITS+1];
	logic [D_W-1:0]      den_sd [DIV_BITS];
	logic                neg_sd [DIV_BITS+1];
	logic                sat_sd [DIV_BITS+1];

	// stage b: shift in fraction bits, saturate if quotient exceeds its cap
	logic [CMP_W-1:0] num_b;
	logic [CMP_W-1:0] thr_b;

	always_comb begin
		num_b = CMP_W'(prod_sa) << FRAC_BITS;
		thr_b = (CMP_W'(den_sa) << 31) + (neg_sa ? CMP_W'(den_sa) : CMP_W'(0));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_sd[0] <= num_b;
			quo_sd[0] <= '0;
			den_sd[0] <= den_sa;
			neg_sd[0] <= neg_sa;
			sat_sd[0] <= (num_b >= thr_b);
		end
	end

	// restoring division, most significant quotient bit first
	for (genvar j = 1; j <= DIV_BITS; j++) begin : g_step
		logic [CMP_W-1:0] trial;
		logic             ge;

		always_comb begin
			trial = CMP_W'(den_sd[j-1]) << (DIV_BITS - j);
			ge    = (rem_sd[j-1] >= trial);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_sd[j] <= {quo_sd[j-1][DIV_BITS-2:0], ge};
				neg_sd[j] <= neg_sd[j-1];
				sat_sd[j] <= sat_sd[j-1];
			end
		end

		// remainder and divisor only needed by later steps
		if (j < DIV_BITS) begin : g_den
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_sd[j] <= ge ? rem_sd[j-1] - trial : rem_sd[j-1];
					den_sd[j] <= den_sd[j-1];
				end
			end
		end
	end

	// apply cap and sign
	logic [31:0] mag_out;

	always_comb begin
		if (sat_sd[DIV_BITS]) begin
			mag_out = neg_sd[DIV_BITS] ? CAP_NEG : CAP_POS;
		end else begin
			mag_out = 32'(quo_sd[DIV_BITS]);
		end
		coord = neg_sd[DIV_BITS] ? 32'd0 - mag_out : mag_out;
	end

endmodule

[sv/perspective_world_to_screen.sv]
// World to screen perspective projection with a loadable 4x4 matrix.
// item channel: kind load writes row row_index of the matrix from coef_a..d
//   and gives no result; kind project maps point_x/y/z (with an implied 1)
//   through rows 0, 1 and 3 and divides by w.
// result channel: screen_x, screen_y in Q16.16 and behind; behind points read
//   -1.0 on both coordinates.
// cfg channel: screen_width, screen_height, near_limit; always ready. Write it
//   only while no projection is in flight.
// Throughput: one transaction per cycle on the item channel, loads included,
//   while item.ready is high. Path: a project transaction passes multiply,
//   row sum, scale and the divider with its 32 quotient-bit stages on its way
//   to the result channel.
// A load takes effect for every project transaction accepted after it.
// Stall: a two-entry output buffer sits at the end; while the receiver stalls
//   the block keeps accepting until the second entry fills, then the whole
//   pipeline holds and item.ready drops, losing nothing.
// Reset: the matrix clears to zero, registers take 1920, 1080 and 0.1, and the
//   pipeline and output buffer empty.
module perspective_world_to_screen (
	input  logic            clk,
	input  logic            arst_n,
	pwts_item_if.sink       item,
	pwts_result_if.source   result,
	pwts_cfg_if.sink        cfg
);
	import pwts_pkg::*;

	logic adv;
	logic take;
	logic take_proj;
	logic take_load;
	logic skid_v_q;
	logic out_v_q;

	assign adv        = !skid_v_q;
	assign item.ready = adv;
	assign take       = item.valid && adv;
	assign take_proj  = take && (item.kind == KIND_PROJECT);
	assign take_load  = take && (item.kind == KIND_LOAD);

	// configuration registers
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [NEAR_W-1:0] near_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			near_q   <= NEAR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_WIDTH:  width_q  <= cfg.data[SIZE_W-1:0];
				CFG_HEIGHT: height_q <= cfg.data[SIZE_W-1:0];
				CFG_NEAR:   near_q   <= cfg.data[NEAR_W-1:0];
				default: ;
			endcase
		end
	end

	// matrix store, written one row per load transaction
	logic signed [COEF_W-1:0] mat_q [MAT_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_DEPTH; i++) begin
				mat_q[i] <= '0;
			end
		end else if (take_load) begin
			mat_q[{item.row_index, 2'd0}] <= item.coef_a;
			mat_q[{item.row_index, 2'd1}] <= item.coef_b;
			mat_q[{item.row_index, 2'd2}] <= item.coef_c;
			mat_q[{item.row_index, 2'd3}] <= item.coef_d;
		end
	end

	// valid bits of the front stages and the divider stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic vd_q [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vd_q[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s1 <= take_proj;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			vd_q[0] <= v_s5;
			for (int i = 1; i < DIV_LAT; i++) begin
				vd_q[i] <= vd_q[i-1];
			end
		end
	end

	// lanes 0, 1, 2 use matrix rows 0, 1, 3 (x, y, w)
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [COEF_W-1:0] tr_s1 [3];
	logic signed [SUM_W-1:0]  sum_s2 [3];
	logic signed [COEF_W-1:0] tr_s2 [3];
	logic signed [ROW_W-1:0]  row_s3 [3];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		localparam logic [1:0] R = (l == 2) ? 2'd3 : 2'(l);

		// s1: products taken against the matrix as of acceptance
		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s1[l][0] <= item.point_x * mat_q[{R, 2'd0}];
				prod_s1[l][1] <= item.point_y * mat_q[{R, 2'd1}];
				prod_s1[l][2] <= item.point_z * mat_q[{R, 2'd2}];
				tr_s1[l]      <= mat_q[{R, 2'd3}];
			end
		end

		// s2: exact sum of products
		always_ff @(posedge clk) begin
			if (adv) begin
				sum_s2[l] <= SUM_W'(prod_s1[l][0]) + SUM_W'(prod_s1[l][1])
					+ SUM_W'(prod_s1[l][2]);
				tr_s2[l]  <= tr_s1[l];
			end
		end

		// s3: floor away the low FRAC_BITS fraction bits, add translation
		always_ff @(posedge clk) begin
			if (adv) begin
				row_s3[l] <= ROW_W'(sum_s2[l] >>> FRAC_BITS) + ROW_W'(tr_s2[l]);
			end
		end
	end

	// s4: numerators, divisor 2w and the near test
	logic signed [N_W-1:0] nx_s4, ny_s4;
	logic [D_W-1:0]        den_s4;
	logic                  behind_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s4     <= N_W'(row_s3[0]) + N_W'(row_s3[2]);
			ny_s4     <= N_W'(row_s3[2]) - N_W'(row_s3[1]);
			den_s4    <= {row_s3[2][ROW_W-2:0], 1'b0};
			behind_s4 <= (row_s3[2] < $signed(ROW_W'(near_q))) || (row_s3[2] <= 0);
		end
	end

	// s5: sign and magnitude
	logic [MAG_W-1:0] magx_s5, magy_s5;
	logic             negx_s5, negy_s5;
	logic [D_W-1:0]   den_s5;
	logic             behind_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			magx_s5   <= nx_s4[N_W-1] ? MAG_W'(-nx_s4) : MAG_W'(nx_s4);
			magy_s5   <= ny_s4[N_W-1] ? MAG_W'(-ny_s4) : MAG_W'(ny_s4);
			negx_s5   <= nx_s4[N_W-1];
			negy_s5   <= ny_s4[N_W-1];
			den_s5    <= den_s4;
			behind_s5 <= behind_s4;
		end
	end

	// behind flag travels alongside the dividers
	logic bd_q [DIV_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			bd_q[0] <= behind_s5;
			for (int i = 1; i < DIV_LAT; i++) begin
				bd_q[i] <= bd_q[i-1];
			end
		end
	end

	logic [31:0] coord_x, coord_y;

	pwts_div u_div_x (
		.clk   (clk),
		.adv   (adv),
		.mag   (magx_s5),
		.neg   (negx_s5),
		.size  (width_q),
		.den   (den_s5),
		.coord (coord_x)
	);

	pwts_div u_div_y (
		.clk   (clk),
		.adv   (adv),
		.mag   (magy_s5),
		.neg   (negy_s5),
		.size  (height_q),
		.den   (den_s5),
		.coord (coord_y)
	);

	// output buffer: main entry plus skid entry
	res_t inc_d;
	logic inc_v;
	res_t out_d_q;
	res_t skid_d_q;

	always_comb begin
		inc_v          = vd_q[DIV_LAT-1] && adv;
		inc_d.behind   = bd_q[DIV_LAT-1];
		inc_d.screen_x = bd_q[DIV_LAT-1] ? NEG_ONE : coord_x;
		inc_d.screen_y = bd_q[DIV_LAT-1] ? NEG_ONE : coord_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			out_v_q  <= skid_v_q || inc_v;
			skid_v_q <= 1'b0;
		end else if (inc_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready) begin
			out_d_q <= skid_v_q ? skid_d_q : inc_d;
		end else if (inc_v) begin
			skid_d_q <= inc_d;
		end
	end

	assign result.valid    = out_v_q;
	assign result.screen_x = out_d_q.screen_x;
	assign result.screen_y = out_d_q.screen_y;
	assign result.behind   = out_d_q.behind;

	// skid entry is only ever filled behind a held main entry
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid while output empty");

	// a drained main entry is refilled from the skid entry
	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && result.ready && skid_v_q) |=> out_v_q)
		else $error("skid entry lost on output pop");

	// behind results carry -1.0 on both coordinates
	a_behind_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.behind) |->
		(result.screen_x == NEG_ONE && result.screen_y == NEG_ONE))
		else $error("behind result with coordinates other than -1");

endmodule

[sim/tb_scoreboard.sv]
class proj_scoreboard;
	typedef struct {
		logic [31:0] sx;
		logic [31:0] sy;
		logic        behind;
	} screen_pt_t;

	logic [31:0] matrix [16];
	logic [14:0] width_px;
	logic [14:0] height_px;
	logic [30:0] near_w;
	screen_pt_t  pending [$];
	int          errors;
	int          points_done;
	int          behind_seen;
	int          sat_seen;

	function new();
		for (int i = 0; i < 16; i++) matrix[i] = '0;
		width_px   = 15'd1920;
		height_px  = 15'd1080;
		near_w     = 31'd6554;
		errors     = 0;
		points_done = 0;
		behind_seen = 0;
		sat_seen   = 0;
	endfunction

	function void set_reg(pwts_pkg::cfg_idx_t idx, logic [31:0] val);
		case (idx)
			pwts_pkg::CFG_WIDTH: begin
				width_px = val[14:0];
			end
			pwts_pkg::CFG_HEIGHT: begin
				height_px = val[14:0];
			end
			pwts_pkg::CFG_NEAR: begin
				near_w = val[30:0];
			end
			default: begin
			end
		endcase
	endfunction

	// floor((x*a + y*b + z*c) / 2^F) + d, exact in wide signed math
	function logic signed [95:0] row_dot(int r, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		logic signed [95:0] acc;
		acc = 96'(x) * 96'($signed(matrix[r*4])) + 96'(y) * 96'($signed(matrix[r*4+1]))
			+ 96'(z) * 96'($signed(matrix[r*4+2]));
		acc = acc >>> pwts_pkg::FRAC_BITS;
		return acc + 96'($signed(matrix[r*4+3]));
	endfunction

	// n * size * 2^F / (2w), truncated toward zero and saturated
	function logic [31:0] scale_coord(logic signed [95:0] n, logic signed [95:0] w,
			logic [14:0] size);
		logic [191:0] mag, q;
		logic         neg;
		neg = n < 0;
		mag = neg ? 192'(-n) : 192'(n);
		q = (mag * 192'(size) << pwts_pkg::FRAC_BITS) / (192'(w) * 2);
		if (!neg) begin
			if (q > 192'h7FFF_FFFF) begin
				sat_seen++;
				return pwts_pkg::CAP_POS;
			end
			return q[31:0];
		end
		if (q > 192'h8000_0000) begin
			sat_seen++;
			return pwts_pkg::CAP_NEG;
		end
		return 32'(-q[31:0]);
	endfunction

	// note one accepted input transaction
	function void note_item(pwts_pkg::kind_t kind, logic [1:0] row, logic [31:0] a,
			logic [31:0] b, logic [31:0] c, logic [31:0] d, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		logic signed [95:0] qx, qy, w;
		screen_pt_t e;
		if (kind == pwts_pkg::KIND_LOAD) begin
			matrix[row*4]   = a;
			matrix[row*4+1] = b;
			matrix[row*4+2] = c;
			matrix[row*4+3] = d;
			return;
		end
		qx = row_dot(0, x, y, z);
		qy = row_dot(1, x, y, z);
		w  = row_dot(3, x, y, z);
		if (w < 96'(near_w) || w <= 0) begin
			e.sx = pwts_pkg::NEG_ONE;
			e.sy = pwts_pkg::NEG_ONE;
			e.behind = 1'b1;
			behind_seen++;
		end else begin
			e.sx = scale_coord(qx + w, w, width_px);
			e.sy = scale_coord(w - qy, w, height_px);
			e.behind = 1'b0;
		end
		pending.insert(pending.size(), e);
	endfunction

	task report(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	// check one accepted result transaction
	task check_result(logic [31:0] sx, logic [31:0] sy, logic behind);
		screen_pt_t e;
		points_done++;
		if (pending.size() == 0) begin
			report($sformatf("unexpected result x=%h y=%h", sx, sy));
			return;
		end
		e = pending.pop_front();
		if (sx !== e.sx) report($sformatf("screen_x %h, want %h", sx, e.sx));
		if (sy !== e.sy) report($sformatf("screen_y %h, want %h", sy, e.sy));
		if (behind !== e.behind) report($sformatf("behind %b, want %b", behind, e.behind));
	endtask
endclass

[sim/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pwts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 1530;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	bit   calm = 1'b0;
	bit   feed_done = 1'b0;

	pwts_item_if   item ();
	pwts_result_if result ();
	pwts_cfg_if    cfg ();

	perspective_world_to_screen dut (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result), .cfg(cfg)
	);

	proj_scoreboard sb = new();

	always #4 clk = ~clk;

	initial begin
		item.valid = 1'b0;
		item.kind = 1'b0;
		item.row_index = '0;
		item.coef_a = '0;
		item.coef_b = '0;
		item.coef_c = '0;
		item.coef_d = '0;
		item.point_x = '0;
		item.point_y = '0;
		item.point_z = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top failed");
			$finish;
		end
	end

	// receiver: random stall bursts, none in the calm tail
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result.valid && result.ready)
				sb.check_result(result.screen_x, result.screen_y, result.behind);
			if (!calm && $urandom_range(0, 9) == 0 && result.ready) begin
				gap = $urandom_range(1, 11);
				result.ready <= 1'b0;
				repeat (gap) begin
					@(posedge clk);
				end
				result.ready <= 1'b1;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// one item transaction; valid stays high into the next call unless a random gap drops it outside the calm tail
	task automatic send_item(kind_t kind, logic [1:0] row, logic [31:0] a, logic [31:0] b,
			logic [31:0] c, logic [31:0] d, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		item.valid <= 1'b1;
		item.kind <= kind;
		item.row_index <= row;
		item.coef_a <= a;
		item.coef_b <= b;
		item.coef_c <= c;
		item.coef_d <= d;
		item.point_x <= x;
		item.point_y <= y;
		item.point_z <= z;
		do @(posedge clk); while (!item.ready);
		sb.note_item(kind, row, a, b, c, d, x, y, z);
		if (!calm && $urandom_range(0, 9) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic load_row(logic [1:0] row, logic [31:0] a, logic [31:0] b,
			logic [31:0] c, logic [31:0] d);
		send_item(KIND_LOAD, row, a, b, c, d, $urandom, $urandom, $urandom);
	endtask

	task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		send_item(KIND_PROJECT, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
			x, y, z);
	endtask

	// stop feeding, let every result drain, then the pipeline settle
	task automatic drain();
		item.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DIV_LAT + 10) @(posedge clk);
	endtask

	// one register write, after which the cfg channel goes idle
	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(idx, val);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly modest values, sometimes full-range
	function automatic logic [31:0] coef_val();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return 32'(0);
			default: return 32'($signed($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	task automatic sane_camera();
		load_row(2'd0, 32'h0001_0000, 0, 0, 0);
		load_row(2'd1, 0, 32'h0001_0000, 0, 0);
		load_row(2'd2, 0, 0, 32'h0001_0000, 0);
		load_row(2'd3, 0, 0, 32'h0001_0000, 32'h0000_8000);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero matrix gives w=0, always behind
		project(0, 0, 0);
		project(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		sane_camera();
		project(0, 0, 32'h0001_0000);
		project(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
		project(0, 0, 32'hFFFF_0000);
		project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0100);
		project(32'h8000_0000, 32'h8000_0000, 32'h0000_0100);
		project(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		load_row(2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		project(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		project(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		load_row(2'd3, 0, 0, 0, 32'h0000_1999);
		project(1, 2, 3);
		load_row(2'd3, 0, 0, 0, 32'h0000_199A);
		project(1, 2, 3);
		drain();

		// extremes of settings: zero sizes and zero near limit
		write_reg(CFG_WIDTH, 0);
		write_reg(CFG_HEIGHT, 32'hFFFF_8000);
		write_reg(CFG_NEAR, 0);
		load_row(2'd3, 0, 0, 0, 1);
		project(32'h0005_0000, 32'h0003_0000, 0);
		load_row(2'd3, 0, 0, 0, 0);
		project(32'h0005_0000, 32'h0003_0000, 0);
		drain();

		// random phases over several settings; pause until empty between them
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_WIDTH, 1920); write_reg(CFG_HEIGHT, 1080);
					write_reg(CFG_NEAR, 6554); end
				1: begin write_reg(CFG_WIDTH, 16384); write_reg(CFG_HEIGHT, 1);
					write_reg(CFG_NEAR, 32'h7FFF_FFFF); end
				2: begin write_reg(CFG_WIDTH, 1); write_reg(CFG_HEIGHT, 16384);
					write_reg(CFG_NEAR, 0); end
				3: begin write_reg(CFG_WIDTH, 32'h7FFF); write_reg(CFG_HEIGHT, 32'h7FFF);
					write_reg(CFG_NEAR, 32'h8000_0000); end
				default: begin write_reg(CFG_WIDTH, $urandom); write_reg(CFG_HEIGHT, $urandom);
					write_reg(CFG_NEAR, $urandom_range(0, 65536)); end
			endcase
			if (ph == 5) calm = 1'b1;
			sane_camera();
			for (int i = 0; i < RAND_ITEMS / 6; i++) begin
				if ($urandom_range(0, 9) == 0)
					load_row(2'($urandom), coef_val(), coef_val(), coef_val(), coef_val());
				else
					project(coef_val(), coef_val(), coef_val());
			end
			drain();
		end

		$display("covered %0d projections (%0d behind, %0d saturated coords)",
			sb.points_done, sb.behind_seen, sb.sat_seen);
		$display("over six register settings plus directed corner cases");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
